>>> sv/adc2w_pkg.sv
// types and constants shared by the two-wire adc serial master
package adc2w_pkg;

  // request codes carried in the action field
  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_READ_CONV = 2'd1,
    ACT_READ_CFG  = 2'd2,
    ACT_WRITE_CFG = 2'd3
  } action_e;

  // sequencer phases, one-hot
  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_WAIT    = 5'b00010,
    PH_HIGH    = 5'b00100,
    PH_LOW     = 5'b01000,
    PH_RELEASE = 5'b10000
  } phase_e;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd360;

  // 7-bit command words
  localparam logic [6:0] CMD_READ  = 7'h56;
  localparam logic [6:0] CMD_WRITE = 7'h65;

  // clock counts and clock windows
  localparam logic [5:0] CONV_CLOCKS = 6'd27;
  localparam logic [5:0] CFG_CLOCKS  = 6'd46;
  localparam logic [5:0] CONV_BITS   = 6'd24;
  localparam logic [5:0] CMD_FIRST   = 6'd29;
  localparam logic [5:0] CMD_LAST    = 6'd35;
  localparam logic [5:0] BYTE_FIRST  = 6'd37;
  localparam logic [5:0] BYTE_LAST   = 6'd44;

  // one system tick of input
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] write_value;
    logic       data_pin_in;
  } in_item_t;

  // pin levels and status after one tick
  typedef struct packed {
    logic        clock_pin;
    logic        data_drive_enable;
    logic        data_pin_out;
    logic [23:0] conversion_value;
    logic [7:0]  config_value;
    logic        busy_res;
    logic        done_res;
  } out_item_t;

endpackage

>>> sv/adc_two_wire_serial_master.sv
// two-wire clock/data serial master for a 24-bit sigma-delta adc
// Each input item is one system tick: an optional request (taken only while idle) and the
// sampled data pin level. Every item yields exactly one result item holding the pin levels to
// drive, busy/done flags and the captured conversion word and config byte. The pin sequencer
// state advances by one tick per accepted item in a single register stage, so one item is
// taken every clock cycle and its result sits in the output register from the next cycle on;
// a new item is taken while that result is being read out, and only a stall on the output
// side with a result still held stops input. The half period register (reset 360 ticks, zero
// treated as one) applies at once when written, also in the middle of a transfer; write it
// only while no item is in flight.
module adc_two_wire_serial_master
  import adc2w_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o
);

  // master drives data during the command, and the byte on a write
  function automatic logic cfg_drive(action_e kind, logic [5:0] k);
    logic res;
    res = 1'b0;
    if (kind == ACT_READ_CFG || kind == ACT_WRITE_CFG) begin
      if (k inside {[CMD_FIRST:CMD_LAST]}) begin
        res = 1'b1;
      end else if (kind == ACT_WRITE_CFG && (k inside {[BYTE_FIRST:BYTE_LAST]})) begin
        res = 1'b1;
      end
    end
    return res;
  endfunction

  // bit put on the data pin at the rising clock of clock k
  function automatic logic cfg_bit(action_e kind, logic [5:0] k, logic [7:0] sb);
    logic [6:0] cmd;
    logic [5:0] idx;
    logic       res;
    cmd = (kind == ACT_WRITE_CFG) ? CMD_WRITE : CMD_READ;
    idx = 6'd0;
    res = 1'b0;
    if (k inside {[CMD_FIRST:CMD_LAST]}) begin
      idx = CMD_LAST - k;
      res = cmd[idx[2:0]];
    end else if (k inside {[BYTE_FIRST:BYTE_LAST]}) begin
      idx = BYTE_LAST - k;
      res = sb[idx[2:0]];
    end
    return res;
  endfunction

  logic [15:0] half_period_q;
  phase_e      phase_q, phase_d;
  logic [5:0]  clock_count_q, clock_count_d;
  logic [15:0] tick_count_q, tick_count_d;
  logic [23:0] capture_shift_q, capture_shift_d;
  logic [7:0]  send_byte_q, send_byte_d;
  action_e     request_kind_q, request_kind_d;
  logic        clock_level_q, clock_level_d;
  logic [7:0]  config_store_q, config_store_d;
  logic        data_level_q, data_level_d;
  logic        out_valid_q;
  out_item_t   out_item_q, out_item_d;

  logic        in_accept;
  logic [15:0] hp;
  logic [15:0] tick_inc;
  logic [5:0]  clock_inc;
  logic [5:0]  total_clocks;
  logic        done;
  logic        drive;
  logic        data_out;

  // handshake: hold input only while a result waits and is stalled
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign hp           = (half_period_q == 16'd0) ? 16'd1 : half_period_q;
  assign tick_inc     = tick_count_q + 16'd1;
  assign clock_inc    = clock_count_q + 6'd1;
  assign total_clocks = (request_kind_q == ACT_READ_CONV) ? CONV_CLOCKS : CFG_CLOCKS;

  // one tick of the pin sequencer
  always_comb begin
    phase_d         = phase_q;
    clock_count_d   = clock_count_q;
    tick_count_d    = tick_count_q;
    capture_shift_d = capture_shift_q;
    send_byte_d     = send_byte_q;
    request_kind_d  = request_kind_q;
    clock_level_d   = clock_level_q;
    config_store_d  = config_store_q;
    data_level_d    = data_level_q;
    done            = 1'b0;

    case (phase_q)
      PH_IDLE: begin
        if (action_e'(in_item_i.action) != ACT_NONE) begin
          request_kind_d = action_e'(in_item_i.action);
          send_byte_d    = in_item_i.write_value;
          clock_count_d  = 6'd0;
          tick_count_d   = 16'd0;
          phase_d        = PH_WAIT;
        end
      end
      PH_WAIT: begin
        // data low means the converter is ready
        if (!in_item_i.data_pin_in) begin
          clock_count_d = 6'd0;
          if (request_kind_q == ACT_READ_CONV) begin
            capture_shift_d = 24'd0;
          end
          phase_d       = PH_HIGH;
          tick_count_d  = 16'd0;
          clock_level_d = 1'b1;
          data_level_d  = cfg_drive(request_kind_q, 6'd0)
                          ? cfg_bit(request_kind_q, 6'd0, send_byte_q) : 1'b0;
        end
      end
      PH_HIGH: begin
        tick_count_d = tick_inc;
        if (tick_inc >= hp) begin
          // sample at the end of the high half
          if (request_kind_q == ACT_READ_CONV && clock_count_q < CONV_BITS) begin
            capture_shift_d = {capture_shift_q[22:0], in_item_i.data_pin_in};
          end
          if (request_kind_q == ACT_READ_CFG
              && (clock_count_q inside {[BYTE_FIRST:BYTE_LAST]})) begin
            send_byte_d = {send_byte_q[6:0], in_item_i.data_pin_in};
          end
          phase_d       = PH_LOW;
          tick_count_d  = 16'd0;
          clock_level_d = 1'b0;
        end
      end
      PH_LOW: begin
        tick_count_d = tick_inc;
        if (tick_inc >= hp) begin
          tick_count_d = 16'd0;
          if (clock_inc >= total_clocks) begin
            clock_count_d = 6'd0;
            data_level_d  = 1'b0;
            if (request_kind_q == ACT_READ_CONV) begin
              phase_d = PH_RELEASE;
            end else begin
              if (request_kind_q == ACT_READ_CFG) begin
                config_store_d = send_byte_q;
              end
              phase_d = PH_IDLE;
              done    = 1'b1;
            end
          end else begin
            // next clock pulse starts high
            clock_count_d = clock_inc;
            phase_d       = PH_HIGH;
            clock_level_d = 1'b1;
            data_level_d  = cfg_drive(request_kind_q, clock_inc)
                            ? cfg_bit(request_kind_q, clock_inc, send_byte_q) : 1'b0;
          end
        end
      end
      PH_RELEASE: begin
        phase_d      = PH_IDLE;
        data_level_d = 1'b0;
        done         = 1'b1;
      end
      default: begin
        phase_d       = PH_IDLE;
        clock_level_d = 1'b0;
        data_level_d  = 1'b0;
      end
    endcase

    // pin drive after the update
    drive = 1'b0;
    if (phase_d == PH_RELEASE) begin
      drive = 1'b1;
    end else if (phase_d == PH_HIGH || phase_d == PH_LOW) begin
      drive = cfg_drive(request_kind_d, clock_count_d);
    end
    if (phase_d == PH_RELEASE) begin
      data_out = 1'b1;
    end else begin
      data_out = drive & data_level_d;
    end

    out_item_d.clock_pin         = clock_level_d;
    out_item_d.data_drive_enable = drive;
    out_item_d.data_pin_out      = data_out;
    out_item_d.conversion_value  = capture_shift_d;
    out_item_d.config_value      = config_store_d;
    out_item_d.busy_res          = (phase_d != PH_IDLE);
    out_item_d.done_res          = done;
  end

  // half period register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HALF_PERIOD_RESET;
    end else if (cfg_we_i) begin
      half_period_q <= cfg_wdata_i;
    end
  end

  // sequencer state, advanced once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_IDLE;
      clock_count_q   <= 6'd0;
      tick_count_q    <= 16'd0;
      capture_shift_q <= 24'd0;
      send_byte_q     <= 8'd0;
      request_kind_q  <= ACT_NONE;
      clock_level_q   <= 1'b0;
      config_store_q  <= 8'd0;
      data_level_q    <= 1'b0;
    end else if (in_accept) begin
      phase_q         <= phase_d;
      clock_count_q   <= clock_count_d;
      tick_count_q    <= tick_count_d;
      capture_shift_q <= capture_shift_d;
      send_byte_q     <= send_byte_d;
      request_kind_q  <= request_kind_d;
      clock_level_q   <= clock_level_d;
      config_store_q  <= config_store_d;
      data_level_q    <= data_out;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_item_q <= out_item_d;
    end
  end

endmodule

>>> tb/sv/adc_two_wire_serial_master_tb.sv
// testbench for the two-wire adc serial master: tick predictor, scoreboard and drivers
`timescale 1ns / 1ps

module adc_two_wire_serial_master_tb
  import adc2w_pkg::*;
();

  localparam int CycleLimit   = 300000;
  localparam int RandomTicks  = 650;
  localparam int SettleCycles = 20;

  // tick-accurate copy of the pin sequencer and the queue of expected pin states
  class pin_sequence_board;
    phase_e      phase;
    action_e     request_kind;
    logic [5:0]  clock_count;
    logic [15:0] tick_count;
    logic [23:0] capture_shift;
    logic [7:0]  send_byte;
    logic [7:0]  config_byte;
    logic        clock_level;
    logic        data_level;
    logic [15:0] half_period;
    out_item_t   expected_pins_q[$];
    int          errors;

    function new();
      phase         = PH_IDLE;
      request_kind  = ACT_NONE;
      clock_count   = '0;
      tick_count    = '0;
      capture_shift = '0;
      send_byte     = '0;
      config_byte   = '0;
      clock_level   = 1'b0;
      data_level    = 1'b0;
      half_period   = HALF_PERIOD_RESET;
      errors        = 0;
    endfunction

    function void set_half_period(logic [15:0] value);
      half_period = value;
    endfunction

    function int pending();
      return expected_pins_q.size();
    endfunction

    // master owns the data pin during the command and, for a write, the byte
    function bit drives_data(logic [5:0] k);
      if (request_kind == ACT_NONE || request_kind == ACT_READ_CONV) return 1'b0;
      if (k >= CMD_FIRST && k <= CMD_LAST) return 1'b1;
      if (request_kind == ACT_WRITE_CFG && k >= BYTE_FIRST && k <= BYTE_LAST) return 1'b1;
      return 1'b0;
    endfunction

    // bit put on the pin for clock k, msb first
    function logic data_bit(logic [5:0] k);
      logic [6:0] cmd;
      logic [5:0] pos;
      cmd = (request_kind == ACT_WRITE_CFG) ? CMD_WRITE : CMD_READ;
      if (k >= CMD_FIRST && k <= CMD_LAST) begin
        pos = CMD_LAST - k;
        return cmd[pos[2:0]];
      end
      if (k >= BYTE_FIRST && k <= BYTE_LAST) begin
        pos = BYTE_LAST - k;
        return send_byte[pos[2:0]];
      end
      return 1'b0;
    endfunction

    function void rise_clock();
      phase       = PH_HIGH;
      tick_count  = '0;
      clock_level = 1'b1;
      data_level  = drives_data(clock_count) ? data_bit(clock_count) : 1'b0;
    endfunction

    // advance one system tick and queue the pin state it produces
    function void advance_tick(in_item_t it);
      logic [15:0] hp;
      logic [5:0]  total;
      logic        done;
      logic        drive;
      out_item_t   pins;
      hp    = (half_period == '0) ? 16'd1 : half_period;
      done  = 1'b0;
      drive = 1'b0;
      case (phase)
        PH_IDLE: begin
          if (it.action != ACT_NONE) begin
            request_kind = action_e'(it.action);
            send_byte    = it.write_value;
            clock_count  = '0;
            tick_count   = '0;
            phase        = PH_WAIT;
          end
        end
        PH_WAIT: begin
          // converter signals ready by pulling data low
          if (!it.data_pin_in) begin
            clock_count = '0;
            if (request_kind == ACT_READ_CONV) capture_shift = '0;
            rise_clock();
          end
        end
        PH_HIGH: begin
          tick_count = tick_count + 16'd1;
          if (tick_count >= hp) begin
            if (request_kind == ACT_READ_CONV && clock_count < CONV_BITS)
              capture_shift = {capture_shift[22:0], it.data_pin_in};
            if (request_kind == ACT_READ_CFG && clock_count >= BYTE_FIRST &&
                clock_count <= BYTE_LAST)
              send_byte = {send_byte[6:0], it.data_pin_in};
            phase       = PH_LOW;
            tick_count  = '0;
            clock_level = 1'b0;
          end
        end
        PH_LOW: begin
          tick_count = tick_count + 16'd1;
          if (tick_count >= hp) begin
            total       = (request_kind == ACT_READ_CONV) ? CONV_CLOCKS : CFG_CLOCKS;
            clock_count = clock_count + 6'd1;
            tick_count  = '0;
            if (clock_count >= total) begin
              clock_count = '0;
              data_level  = 1'b0;
              if (request_kind == ACT_READ_CONV) begin
                phase = PH_RELEASE;
              end else begin
                if (request_kind == ACT_READ_CFG) config_byte = send_byte;
                phase = PH_IDLE;
                done  = 1'b1;
              end
            end else begin
              rise_clock();
            end
          end
        end
        PH_RELEASE: begin
          phase      = PH_IDLE;
          data_level = 1'b0;
          done       = 1'b1;
        end
        default: begin
          phase       = PH_IDLE;
          clock_level = 1'b0;
          data_level  = 1'b0;
        end
      endcase

      // pin ownership after the update
      if (phase == PH_RELEASE) begin
        drive      = 1'b1;
        data_level = 1'b1;
      end else if (phase == PH_HIGH || phase == PH_LOW) begin
        drive = drives_data(clock_count);
      end
      if (!drive) data_level = 1'b0;

      pins.clock_pin         = clock_level;
      pins.data_drive_enable = drive;
      pins.data_pin_out      = data_level;
      pins.conversion_value  = capture_shift;
      pins.config_value      = config_byte;
      pins.busy_res          = (phase != PH_IDLE);
      pins.done_res          = done;
      expected_pins_q.push_back(pins);
    endfunction

    function void flag(string field, logic [23:0] want, logic [23:0] got);
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, field, want, got);
    endfunction

    // compare one result item with the oldest expected pin state
    function void check_pins(out_item_t got);
      out_item_t want;
      if (expected_pins_q.size() == 0) begin
        errors++;
        $display("%0t: result expected none got %h", $time, got);
        return;
      end
      want = expected_pins_q.pop_front();
      if (got.clock_pin !== want.clock_pin)
        flag("clock_pin", 24'(want.clock_pin), 24'(got.clock_pin));
      if (got.data_drive_enable !== want.data_drive_enable)
        flag("data_drive_enable", 24'(want.data_drive_enable), 24'(got.data_drive_enable));
      if (got.data_pin_out !== want.data_pin_out)
        flag("data_pin_out", 24'(want.data_pin_out), 24'(got.data_pin_out));
      if (got.conversion_value !== want.conversion_value)
        flag("conversion_value", want.conversion_value, got.conversion_value);
      if (got.config_value !== want.config_value)
        flag("config_value", 24'(want.config_value), 24'(got.config_value));
      if (got.busy_res !== want.busy_res)
        flag("busy_res", 24'(want.busy_res), 24'(got.busy_res));
      if (got.done_res !== want.done_res)
        flag("done_res", 24'(want.done_res), 24'(got.done_res));
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;

  pin_sequence_board sb;
  int cycle_count = 0;
  int burst_left  = 0;
  int stall_mode  = 0;
  int stall_span  = 0;

  adc_two_wire_serial_master uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stall pattern: free, random, or periodic stretches
  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_span <= $urandom_range(50, 300);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 2) == 0);
      default: out_stall_i <= ((cycle_count % 5) < 2);
    endcase
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_pins(out_item_o);
  end

  // hold one item until taken, then record it
  task automatic send_tick(input in_item_t it);
    int gap;
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.advance_tick(it);
    // bursts with random gaps between them
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // stop sending and wait for every expected result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
  endtask

  task automatic write_half_period(input logic [15:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_half_period(value);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_half_period();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'd2;
      2:       return 16'd3;
      3:       return 16'($urandom_range(4, 6));
      default: return 16'd1;
    endcase
  endfunction

  // mostly requests when idle and ready when waiting, noise otherwise
  function automatic in_item_t random_tick();
    in_item_t it;
    int       r;
    r               = $urandom_range(0, 99);
    it.write_value  = pick_byte();
    it.action       = ACT_NONE;
    it.data_pin_in  = 1'($urandom_range(0, 1));
    case (sb.phase)
      PH_IDLE: if (r < 75) it.action = 2'($urandom_range(1, 3));
      PH_WAIT: begin
        it.data_pin_in = (r < 55) ? 1'b0 : 1'b1;
        if ($urandom_range(0, 4) == 0) it.action = 2'($urandom_range(0, 3));
      end
      default: if (r < 25) it.action = 2'($urandom_range(0, 3));
    endcase
    return it;
  endfunction

  initial begin
    int random_count;
    int n;
    random_count = 0;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset half period: request, wait for ready, ignored requests while busy
    send_tick(in_item_t'{action: ACT_NONE,      write_value: 8'h00, data_pin_in: 1'b1});
    send_tick(in_item_t'{action: ACT_READ_CONV, write_value: 8'hFF, data_pin_in: 1'b1});
    send_tick(in_item_t'{action: ACT_NONE,      write_value: 8'h00, data_pin_in: 1'b1});
    send_tick(in_item_t'{action: ACT_WRITE_CFG, write_value: 8'hFF, data_pin_in: 1'b1});
    send_tick(in_item_t'{action: ACT_READ_CFG,  write_value: 8'h00, data_pin_in: 1'b0});
    repeat (4)
      send_tick(in_item_t'{action: ACT_NONE, write_value: 8'hA5,
                           data_pin_in: 1'($urandom_range(0, 1))});

    // largest half period mid-transfer
    drain();
    write_half_period(16'hFFFF);
    repeat (3)
      send_tick(in_item_t'{action: ACT_WRITE_CFG, write_value: 8'h5A, data_pin_in: 1'b1});

    // zero half period acts as one; the long high half ends on the next tick
    drain();
    write_half_period(16'h0000);
    repeat (8)
      send_tick(in_item_t'{action: ACT_NONE, write_value: 8'h00,
                           data_pin_in: 1'($urandom_range(0, 1))});

    // random phases, each with its own half period
    while (random_count < RandomTicks) begin
      drain();
      write_half_period(pick_half_period());
      n = $urandom_range(40, 120);
      repeat (n) begin
        send_tick(random_tick());
        random_count++;
      end
    end

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
